### rtl/core/hsom_pkg.sv
`default_nettype none

package hsom_pkg;

	// Sizes of the grid, the heights and the configuration registers.
	localparam int MAX_WIDTH   = 1024;
	localparam int ADDR_W      = $clog2(MAX_WIDTH);
	localparam int HEIGHT_BITS = 24;
	localparam int DIM_W       = 11;
	localparam int STEP_W      = 23;
	localparam int POS_W       = 10;
	localparam int CFG_W       = 23;
	localparam int CFG_IDX_W   = 2;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 3);

	localparam logic [DIM_W-1:0]  ROW_SAT     = '1;
	localparam logic [DIM_W-1:0]  WIDTH_RESET = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0]  ROWS_RESET  = 11'd1024;
	localparam logic [STEP_W-1:0] STEP_RESET  = 23'd800;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH = 2'd0,
		REG_GRID_ROWS  = 2'd1,
		REG_MAX_STEP   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic                          hit;
		logic signed [HEIGHT_BITS-1:0] h;
	} cell_t;

	// One line buffer word: the previous row and the row before it.
	typedef struct packed {
		cell_t prev;
		cell_t older;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Control that travels with an accepted beat from the scan counters.
	typedef struct packed {
		logic             vld;
		logic             res;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             top_ok;
		logic             left_ok;
		logic             right_ok;
		logic             below_ok;
		logic             last;
	} tag_t;

	typedef struct packed {
		logic                          we;
		logic [ADDR_W-1:0]             addr;
		entry_t                        data;
	} wr_t;

	typedef struct packed {
		logic [POS_W-1:0]              col;
		logic [POS_W-1:0]              row;
		logic                          obst;
		logic signed [HEIGHT_BITS-1:0] height;
		logic                          last;
	} res_t;

endpackage

`default_nettype wire

### rtl/core/height_step_obstacle_marker.sv
`default_nettype none

// Channel   | Handshake                 | Beat contents
// ----------+---------------------------+------------------------------------------------
// config    | cfg_we                    | cfg_idx, cfg_data
// cells in  | in_valid / in_stall       | start_of_frame, cell_hit, surface_height
// results   | out_valid / out_stall     | cell_col, cell_row, is_obstacle, saved_height,
//           |                           | last_cell
//
// One cell beat is taken per clock while in_stall is low; its result, if any, passes
// through the s1 and s2 registers into the output queue.
// The rate is set by the single line-buffer memory: one read-modify-write per cell
// through two read ports, with registered reads and write forwarding.
// After reset the block clears every line-buffer entry and holds in_stall high meanwhile.
// Results wait in a four-entry queue; in_stall rises while the line buffers are cleared
// and when that queue and the cells in flight fill it, so output stalls never drop or repeat a beat.

module height_step_obstacle_marker
	import hsom_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]          cfg_idx,
	input  wire logic [CFG_W-1:0]              cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          start_of_frame,
	input  wire logic                          cell_hit,
	input  wire logic signed [HEIGHT_BITS-1:0] surface_height,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [POS_W-1:0]                   cell_col,
	output logic [POS_W-1:0]                   cell_row,
	output logic                               is_obstacle,
	output logic signed [HEIGHT_BITS-1:0]      saved_height,
	output logic                               last_cell
);

	// Configuration registers.
	logic [DIM_W-1:0]  grid_width_q;
	logic [DIM_W-1:0]  grid_rows_q;
	logic [STEP_W-1:0] max_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= WIDTH_RESET;
			grid_rows_q  <= ROWS_RESET;
			max_step_q   <= STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_GRID_WIDTH: grid_width_q <= cfg_data[DIM_W-1:0];
				REG_GRID_ROWS:  grid_rows_q  <= cfg_data[DIM_W-1:0];
				REG_MAX_STEP:   max_step_q   <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tag_t                  tag_s0;
	logic [ADDR_W-1:0]     raddr_a;
	logic [ADDR_W-1:0]     raddr_b;
	logic                  clr_busy;
	logic [ADDR_W-1:0]     clr_addr;
	entry_t                rdata_a;
	entry_t                rdata_b;
	wr_t                   wr;
	logic                  push;
	res_t                  push_data;
	logic [1:0]            inflight;
	logic [FIFO_CNT_W-1:0] fifo_count;
	logic [FIFO_CNT_W-1:0] pending;
	logic                  full;
	res_t                  head;

	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	entry_t                ram_wdata;

	// Every result already in flight or queued holds a queue slot in advance.
	assign pending = fifo_count + FIFO_CNT_W'(inflight);
	assign full    = pending >= FIFO_CNT_W'(FIFO_DEPTH);

	hsom_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.start_of_frame (start_of_frame),
		.grid_width     (grid_width_q),
		.grid_rows      (grid_rows_q),
		.full           (full),
		.in_stall       (in_stall),
		.tag_s0         (tag_s0),
		.raddr_a        (raddr_a),
		.raddr_b        (raddr_b),
		.clr_busy       (clr_busy),
		.clr_addr       (clr_addr)
	);

	// The clearing sweep owns the write port until it is done.
	assign ram_we    = clr_busy || wr.we;
	assign ram_waddr = clr_busy ? clr_addr : wr.addr;
	assign ram_wdata = clr_busy ? '0 : wr.data;

	hsom_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	hsom_judge u_judge (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s0    (tag_s0),
		.cur_hit   (cell_hit),
		.cur_h     (surface_height),
		.raddr_a   (raddr_a),
		.raddr_b   (raddr_b),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.max_step  (max_step_q),
		.wr        (wr),
		.push      (push),
		.push_data (push_data),
		.inflight  (inflight)
	);

	hsom_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (!out_stall),
		.not_empty (out_valid),
		.head      (head),
		.count     (fifo_count)
	);

	assign cell_col     = head.col;
	assign cell_row     = head.row;
	assign is_obstacle  = head.obst;
	assign saved_height = head.height;
	assign last_cell    = head.last;

endmodule

`default_nettype wire

### rtl/core/hsom_ram.sv
`default_nettype none

module hsom_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Reads return the contents from before a write to the same address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

### rtl/core/hsom_scan.sv
`default_nettype none

module hsom_scan
	import hsom_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              start_of_frame,
	input  wire logic [DIM_W-1:0]  grid_width,
	input  wire logic [DIM_W-1:0]  grid_rows,
	input  wire logic              full,
	output logic                   in_stall,
	output tag_t                   tag_s0,
	output logic [ADDR_W-1:0]      raddr_a,
	output logic [ADDR_W-1:0]      raddr_b,
	output logic                   clr_busy,
	output logic [ADDR_W-1:0]      clr_addr
);

	logic [POS_W-1:0]  col_q;
	logic [DIM_W-1:0]  row_q;
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic [DIM_W-1:0]  eff_w;
	logic [POS_W-1:0]  col_base;
	logic [POS_W-1:0]  col_cur;
	logic [DIM_W-1:0]  row_cur;
	logic [DIM_W-1:0]  col_next;
	logic [DIM_W-1:0]  row_above;
	logic              wrap;
	logic              accept;

	always_comb begin
		if (grid_width == '0) begin
			eff_w = DIM_W'(1);
		end else if (grid_width > DIM_W'(MAX_WIDTH)) begin
			eff_w = DIM_W'(MAX_WIDTH);
		end else begin
			eff_w = grid_width;
		end
		col_base  = start_of_frame ? '0 : col_q;
		col_cur   = ({1'b0, col_base} >= eff_w) ? '0 : col_base;
		row_cur   = start_of_frame ? '0 : row_q;
		col_next  = {1'b0, col_cur} + DIM_W'(1);
		wrap      = col_next >= eff_w;
		row_above = row_cur - DIM_W'(1);
	end

	assign in_stall = clr_busy_q || full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		tag_s0.vld      = accept;
		tag_s0.res      = accept && (row_cur != '0) && (row_above < grid_rows);
		tag_s0.col      = col_cur;
		tag_s0.row      = row_above[POS_W-1:0];
		tag_s0.top_ok   = row_above != '0;
		tag_s0.left_ok  = col_cur != '0;
		tag_s0.right_ok = !wrap;
		tag_s0.below_ok = row_cur < grid_rows;
		tag_s0.last     = (row_cur == grid_rows) && wrap;
	end

	assign raddr_a = ADDR_W'(col_cur);
	assign raddr_b = ADDR_W'(col_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (wrap) begin
				col_q <= '0;
				row_q <= (row_cur == ROW_SAT) ? row_cur : row_cur + DIM_W'(1);
			end else begin
				col_q <= col_next[POS_W-1:0];
				row_q <= row_cur;
			end
		end
	end

	// Sweep both line buffers to zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign clr_busy = clr_busy_q;
	assign clr_addr = clr_addr_q;

endmodule

`default_nettype wire

### rtl/core/hsom_judge.sv
`default_nettype none

module hsom_judge
	import hsom_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tag_t                          tag_s0,
	input  wire logic                          cur_hit,
	input  wire logic signed [HEIGHT_BITS-1:0] cur_h,
	input  wire logic [ADDR_W-1:0]             raddr_a,
	input  wire logic [ADDR_W-1:0]             raddr_b,
	input  wire entry_t                        rdata_a,
	input  wire entry_t                        rdata_b,
	input  wire logic [STEP_W-1:0]             max_step,
	output wr_t                                wr,
	output logic                               push,
	output res_t                               push_data,
	output logic [1:0]                         inflight
);

	localparam int DW = HEIGHT_BITS + 1;

	tag_t   tag_s1;
	cell_t  cur_s1;
	logic   fwd_a_s1;
	logic   fwd_b_s1;
	entry_t fwd_s1;
	cell_t  left_q;

	entry_t entry_a;
	entry_t entry_b;
	cell_t  self;

	logic                          res_s2;
	logic [POS_W-1:0]              col_s2;
	logic [POS_W-1:0]              row_s2;
	logic                          last_s2;
	logic                          self_hit_s2;
	logic signed [HEIGHT_BITS-1:0] self_h_s2;
	logic [3:0]                    need_s2;
	logic signed [DW-1:0]          diff_s2 [4];

	logic [3:0]                    need;
	logic signed [DW-1:0]          diff [4];
	logic signed [DW-1:0]          step_ext;
	logic [3:0]                    steep;

	function automatic logic signed [DW-1:0] height_diff(cell_t a, cell_t b);
		height_diff = {a.h[HEIGHT_BITS-1], a.h} - {b.h[HEIGHT_BITS-1], b.h};
	endfunction

	// A write leaving stage one in the same cycle as a read of that entry.
	assign entry_a = fwd_a_s1 ? fwd_s1 : rdata_a;
	assign entry_b = fwd_b_s1 ? fwd_s1 : rdata_b;
	assign self    = entry_a.prev;

	always_comb begin
		wr.we         = tag_s1.vld;
		wr.addr       = ADDR_W'(tag_s1.col);
		wr.data.prev  = cur_s1;
		wr.data.older = self;
	end

	always_comb begin
		need[0] = tag_s1.top_ok   && entry_a.older.hit;
		need[1] = tag_s1.left_ok  && left_q.hit;
		need[2] = tag_s1.right_ok && entry_b.prev.hit;
		need[3] = tag_s1.below_ok && cur_s1.hit;
		diff[0] = height_diff(self, entry_a.older);
		diff[1] = height_diff(self, left_q);
		diff[2] = height_diff(self, entry_b.prev);
		diff[3] = height_diff(self, cur_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			res_s2 <= 1'b0;
		end else begin
			tag_s1 <= tag_s0;
			res_s2 <= tag_s1.res;
		end
	end

	always_ff @(posedge clk) begin
		cur_s1.hit      <= cur_hit;
		cur_s1.h        <= cur_h;
		fwd_a_s1        <= wr.we && (wr.addr == raddr_a);
		fwd_b_s1        <= wr.we && (wr.addr == raddr_b);
		fwd_s1          <= wr.data;
		if (tag_s1.vld) begin
			left_q <= self;
		end
		col_s2      <= tag_s1.col;
		row_s2      <= tag_s1.row;
		last_s2     <= tag_s1.last;
		self_hit_s2 <= self.hit;
		self_h_s2   <= self.h;
		need_s2     <= need;
		diff_s2     <= diff;
	end

	// A step is steep when it lies above max_step or below its negative.
	assign step_ext = $signed({{(DW - STEP_W){1'b0}}, max_step});

	always_comb begin
		logic signed [DW:0] sum;
		for (int k = 0; k < 4; k++) begin
			sum      = {diff_s2[k][DW-1], diff_s2[k]} + {step_ext[DW-1], step_ext};
			steep[k] = need_s2[k] && ((diff_s2[k] > step_ext) || sum[DW]);
		end
	end

	always_comb begin
		push             = res_s2;
		push_data.col    = col_s2;
		push_data.row    = row_s2;
		push_data.obst   = self_hit_s2 && (steep != '0);
		push_data.height = self_hit_s2 ? self_h_s2 : '0;
		push_data.last   = last_s2;
	end

	assign inflight = {1'b0, tag_s1.res} + {1'b0, res_s2};

endmodule

`default_nettype wire

### rtl/core/hsom_ofifo.sv
`default_nettype none

module hsom_ofifo
	import hsom_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire res_t              push_data,
	input  wire logic              pop,
	output logic                   not_empty,
	output res_t                   head,
	output logic [FIFO_CNT_W-1:0]  count
);

	res_t                  slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_pop;

	assign not_empty = count_q != '0;
	assign do_pop    = pop && not_empty;
	assign head      = slot_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
		end
	end

endmodule

`default_nettype wire
